>>> design/tspg_pkg.sv
// ----------------------------------------------------------------------------
// tspg_pkg: shared types and constants for the three-axis step pulse generator
// Command codes, sequencer states, the remainder-unit interface and the
// small arithmetic helpers used by the tick sequencer and the remainder unit.
// ----------------------------------------------------------------------------
package tspg_pkg;

    localparam int TICK_W         = 32;
    localparam int COUNT_W        = 17;
    localparam int REQ_W          = 16;
    localparam int LEVEL_W        = 4;
    localparam int CMD_W          = 2;
    localparam int MOTOR_W        = 3;
    localparam int PIN_W          = 3;
    localparam int CFG_INDEX_W    = 2;
    localparam int NUM_LEVEL_REGS = 3;
    localparam int LEVEL_RESET    = 5;
    localparam int LEVEL_MAX      = 10;
    localparam int DIV_BASE       = 11;

    // remainder unit walks the tick counter one 4-bit digit per cycle
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = TICK_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(NUM_DIGITS);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK  = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_QUERY = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMD,
        S_START,
        S_WAIT,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic               start;
        logic [LEVEL_W-1:0] divisor;
    } rem_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] rem;
    } rem_stat_t;

    // divisor is 11 - level, levels above ten clamp to ten
    function automatic logic [LEVEL_W-1:0] divisor_of(input logic [LEVEL_W-1:0] level);
        logic [LEVEL_W-1:0] lvl;
        lvl = (level > LEVEL_W'(LEVEL_MAX)) ? LEVEL_W'(LEVEL_MAX) : level;
        return LEVEL_W'(DIV_BASE) - lvl;
    endfunction

    // fold one digit into a running remainder, restoring one bit at a time
    function automatic logic [LEVEL_W-1:0] rem_digit(input logic [LEVEL_W-1:0] rem,
                                                     input logic [DIGIT_W-1:0] digit,
                                                     input logic [LEVEL_W-1:0] d);
        logic [LEVEL_W:0] r;
        r = {1'b0, rem};
        for (int i = DIGIT_W - 1; i >= 0; i--)
        begin
            r = {r[LEVEL_W-1:0], digit[i]};
            if (r >= {1'b0, d})
            begin
                r = r - {1'b0, d};
            end
        end
        return r[LEVEL_W-1:0];
    endfunction

endpackage

>>> design/three_axis_step_pulse_generator.sv
// ----------------------------------------------------------------------------
// three_axis_step_pulse_generator: step / direction / enable for stepper motors
// Run, stop and query commands per motor, and a shared tick that steps each
// motor whose speed divisor divides the tick count.
// ----------------------------------------------------------------------------
//  channel | handshake            | beat contents
//  in      | in_valid / in_ready  | command, motor_number, direction, step_request
//  out     | out_valid / out_ready| step_pins, enable_pins, direction_pins,
//          |                      | remaining_half_steps, error_flag
//  cfg     | cfg_valid / cfg_ready| cfg_index (speed level register), cfg_data
//
//  Run, stop and query pass through S_CMD and S_DONE to the result. A tick
//  visits the motors in turn: each one with a nonzero level starts the shared
//  remainder unit in S_START, waits in S_WAIT for its digits and is stepped on
//  a zero remainder; a held motor is skipped. in_ready is high only when the
//  sequencer is idle; a finished result waits in the output register while the
//  next beat is accepted. Reset clears all motor state and sets levels to 5.
// ----------------------------------------------------------------------------
module three_axis_step_pulse_generator
    import tspg_pkg::*;
#(
    parameter int NUM_MOTORS = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [CMD_W-1:0]       command,
    input  logic [MOTOR_W-1:0]     motor_number,
    input  logic                   direction,
    input  logic [REQ_W-1:0]       step_request,

    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [PIN_W-1:0]       step_pins,
    output logic [PIN_W-1:0]       enable_pins,
    output logic [PIN_W-1:0]       direction_pins,
    output logic [COUNT_W-1:0]     remaining_half_steps,
    output logic                   error_flag,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_data
);

    localparam int IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;

    seq_state_t state_reg, state_next;

    // latched command beat
    cmd_t               cmd_reg;
    logic [MOTOR_W-1:0] motor_reg;
    logic               dir_in_reg;
    logic [REQ_W-1:0]   req_reg;

    logic [IDX_W-1:0]   idx_reg;
    logic [TICK_W-1:0]  tick_reg;

    logic [COUNT_W-1:0] count_reg [NUM_MOTORS];
    logic [LEVEL_W-1:0] level_reg [NUM_MOTORS];
    logic [NUM_MOTORS-1:0] phase_reg;
    logic [NUM_MOTORS-1:0] step_reg;
    logic [NUM_MOTORS-1:0] en_reg;
    logic [NUM_MOTORS-1:0] dir_reg;

    logic [COUNT_W-1:0] res_rem_reg;
    logic               res_err_reg;
    logic               out_valid_reg;
    logic [PIN_W-1:0]   out_step_reg;
    logic [PIN_W-1:0]   out_en_reg;
    logic [PIN_W-1:0]   out_dir_reg;
    logic [COUNT_W-1:0] out_rem_reg;
    logic               out_err_reg;

    // control from the output decode
    logic       accept;
    logic       cmd_exec;
    logic       tick_apply;
    logic       idx_step;
    logic       tick_finish;
    logic       out_load;
    rem_ctrl_t  rem_ctrl;
    rem_stat_t  rem_stat;

    logic [IDX_W-1:0]   cmd_idx;
    logic [IDX_W-1:0]   addr;
    logic               motor_ok;
    logic               last_motor;
    logic               held;
    logic [COUNT_W-1:0] cur_count;
    logic [PIN_W-1:0]   step_pack;
    logic [PIN_W-1:0]   en_pack;
    logic [PIN_W-1:0]   dir_pack;

    assign cmd_idx    = IDX_W'(motor_reg - 1'b1);
    assign motor_ok   = (motor_reg != '0) && (int'(motor_reg) <= NUM_MOTORS);
    assign addr       = (state_reg == S_CMD) ? cmd_idx : idx_reg;
    assign last_motor = (idx_reg == IDX_W'(NUM_MOTORS - 1));
    assign held       = (level_reg[addr] == '0);
    assign cur_count  = count_reg[addr];

    tspg_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (rem_ctrl),
        .dividend (tick_reg),
        .stat     (rem_stat)
    );

    // ---------------- sequencer next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (command == CMD_TICK) ? S_START : S_CMD;
                end
            end
            S_CMD:
            begin
                state_next = S_DONE;
            end
            S_START:
            begin
                if (!held)
                begin
                    state_next = S_WAIT;
                end
                else if (last_motor)
                begin
                    state_next = S_DONE;
                end
            end
            S_WAIT:
            begin
                if (rem_stat.done)
                begin
                    state_next = last_motor ? S_DONE : S_START;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        accept           = 1'b0;
        cmd_exec         = 1'b0;
        tick_apply       = 1'b0;
        idx_step         = 1'b0;
        tick_finish      = 1'b0;
        out_load         = 1'b0;
        rem_ctrl.start   = 1'b0;
        rem_ctrl.divisor = divisor_of(level_reg[addr]);
        case (state_reg)
            S_IDLE:
            begin
                accept = in_valid;
            end
            S_CMD:
            begin
                cmd_exec = 1'b1;
            end
            S_START:
            begin
                if (!held)
                begin
                    rem_ctrl.start = 1'b1;
                end
                else
                begin
                    idx_step    = !last_motor;
                    tick_finish = last_motor;
                end
            end
            S_WAIT:
            begin
                if (rem_stat.done)
                begin
                    tick_apply  = (rem_stat.rem == '0);
                    idx_step    = !last_motor;
                    tick_finish = last_motor;
                end
            end
            S_DONE:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
                accept = 1'b0;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            tick_reg      <= '0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            step_reg      <= '0;
            en_reg        <= '0;
            dir_reg       <= '0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                count_reg[i] <= '0;
                level_reg[i] <= LEVEL_W'(LEVEL_RESET);
            end
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
            begin
                idx_reg <= '0;
            end
            else if (idx_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (tick_finish)
            begin
                tick_reg <= tick_reg + 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cfg_valid && (int'(cfg_index) < NUM_LEVEL_REGS)
                && (int'(cfg_index) < NUM_MOTORS))
            begin
                level_reg[IDX_W'(cfg_index)] <= cfg_data;
            end

            // one step of the addressed motor on its tick slot
            if (tick_apply && (cur_count != '0))
            begin
                count_reg[addr] <= cur_count - 1'b1;
                if (cur_count == COUNT_W'(1))
                begin
                    en_reg[addr] <= 1'b0;
                end
                else
                begin
                    step_reg[addr]  <= phase_reg[addr];
                    phase_reg[addr] <= !phase_reg[addr];
                end
            end

            if (cmd_exec && motor_ok)
            begin
                case (cmd_reg)
                    CMD_RUN:
                    begin
                        en_reg[addr]    <= 1'b1;
                        dir_reg[addr]   <= dir_in_reg;
                        count_reg[addr] <= {req_reg, 1'b0};
                    end
                    CMD_STOP:
                    begin
                        en_reg[addr]    <= 1'b0;
                        count_reg[addr] <= '0;
                    end
                    default:
                    begin
                        en_reg[addr] <= en_reg[addr];
                    end
                endcase
            end
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg     <= cmd_t'(command);
            motor_reg   <= motor_number;
            dir_in_reg  <= direction;
            req_reg     <= step_request;
            res_rem_reg <= '0;
            res_err_reg <= 1'b0;
        end
        else if (cmd_exec)
        begin
            res_err_reg <= !motor_ok;
            if (motor_ok && (cmd_reg == CMD_QUERY))
            begin
                res_rem_reg <= cur_count;
            end
        end

        if (out_load)
        begin
            out_step_reg <= step_pack;
            out_en_reg   <= en_pack;
            out_dir_reg  <= dir_pack;
            out_rem_reg  <= res_rem_reg;
            out_err_reg  <= res_err_reg;
        end
    end

    // pins report the first three motors only
    for (genvar g = 0; g < PIN_W; g++)
    begin : g_pack
        if (g < NUM_MOTORS)
        begin : g_live
            assign step_pack[g] = step_reg[g];
            assign en_pack[g]   = en_reg[g];
            assign dir_pack[g]  = dir_reg[g];
        end
        else
        begin : g_none
            assign step_pack[g] = 1'b0;
            assign en_pack[g]   = 1'b0;
            assign dir_pack[g]  = 1'b0;
        end
    end

    assign out_valid            = out_valid_reg;
    assign step_pins            = out_step_reg;
    assign enable_pins          = out_en_reg;
    assign direction_pins       = out_dir_reg;
    assign remaining_half_steps = out_rem_reg;
    assign error_flag           = out_err_reg;

endmodule

>>> design/tspg_rem_unit.sv
// ----------------------------------------------------------------------------
// tspg_rem_unit: tick counter remainder by a small divisor
// Digit-serial remainder of the 32-bit tick counter by a divisor of 1..10,
// one 4-bit digit per cycle, most significant digit first.
// ----------------------------------------------------------------------------
module tspg_rem_unit
    import tspg_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  rem_ctrl_t         ctrl,
    input  logic [TICK_W-1:0] dividend,
    output rem_stat_t         stat
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [DIGIT_CNT_W-1:0] cnt_reg;
    logic [TICK_W-1:0]      shift_reg;
    logic [LEVEL_W-1:0]     rem_reg;
    logic [LEVEL_W-1:0]     div_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DIGIT_CNT_W'(NUM_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= ctrl.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_digit(rem_reg, shift_reg[TICK_W-1 -: DIGIT_W], div_reg);
            shift_reg <= {shift_reg[TICK_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    assign stat.done = done_reg;
    assign stat.rem  = rem_reg;

endmodule
